// ===== design/saob_pkg.sv =====
package saob_pkg;

    localparam int CH_W       = 8;
    localparam int WGT_W      = 2 * CH_W;
    localparam int NUM_W      = 3 * CH_W;
    localparam int NCH        = 3;
    localparam int PRE_STAGES = 3;
    localparam int LATENCY    = PRE_STAGES + CH_W;

    localparam logic [CH_W-1:0] CH_MAX = '1;

    typedef logic [CH_W-1:0]  t_chan;
    typedef logic [WGT_W-1:0] t_wgt;
    typedef logic [NUM_W-1:0] t_num;
    typedef logic [NCH-1:0][CH_W-1:0]  t_rgb;
    typedef logic [NCH-1:0][NUM_W-1:0] t_rgb_num;

    // floor(x / 255) for 16-bit x below 65280
    function automatic t_chan div255(input t_wgt x);
        logic [WGT_W:0] s;
        s = {1'b0, x} + {{(CH_W + 1){1'b0}}, x[WGT_W-1:CH_W]} + {{WGT_W{1'b0}}, 1'b1};
        return s[WGT_W-1:CH_W];
    endfunction

endpackage

// ===== design/straight_alpha_over_blend.sv =====
// Porter-Duff "over" composite of one straight-alpha source pixel onto one
// straight-alpha destination pixel, 8 bits per channel.
// Input: drive the eight channel ports and raise start; a pixel pair is taken
// at each rising edge where start is high and busy is low. busy stays low, so
// one pair can be taken every cycle.
// Output: o_valid marks one cycle in which o_out_alpha and the three colour
// ports hold the blended pixel; the receiver must take it in that cycle.
// Three stages form the weights, the products and the sums with the coverage;
// eight more stages run a restoring divide, one quotient bit per stage, for the
// three colour channels side by side. Throughput is one pixel per clock.
// Colour is 0 where both alphas are 0.
// Reset (synchronous, active low) clears the valid bits of every stage; pixels
// in flight are dropped. There is no back pressure on the result side.
module straight_alpha_over_blend (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_src_alpha,
    input  logic [7:0] i_src_red,
    input  logic [7:0] i_src_green,
    input  logic [7:0] i_src_blue,
    input  logic [7:0] i_dst_alpha,
    input  logic [7:0] i_dst_red,
    input  logic [7:0] i_dst_green,
    input  logic [7:0] i_dst_blue,
    output logic       o_valid,
    output logic [7:0] o_out_alpha,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue
);

    localparam int CH_W = saob_pkg::CH_W;
    localparam int NCH  = saob_pkg::NCH;

    logic accept;

    // weight stage
    logic            r1_vld;
    saob_pkg::t_wgt  r1_wsrc;
    saob_pkg::t_wgt  r1_wdst;
    saob_pkg::t_rgb  r1_src;
    saob_pkg::t_rgb  r1_dst;

    // product stage
    logic                r2_vld;
    saob_pkg::t_wgt      r2_cov;
    saob_pkg::t_rgb_num  r2_ps;
    saob_pkg::t_rgb_num  r2_pd;

    // divide stages, index 0 is the sum stage
    logic                r_vld   [0:CH_W];
    saob_pkg::t_rgb_num  r_rem   [0:CH_W];
    saob_pkg::t_rgb      r_q     [0:CH_W];
    saob_pkg::t_wgt      r_div   [0:CH_W];
    saob_pkg::t_chan     r_alpha [0:CH_W];
    logic                r_nz    [0:CH_W];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r_vld[0] <= 1'b0;
        end else begin
            r1_vld <= accept;
            r2_vld <= r1_vld;
            r_vld[0] <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_wsrc <= {i_src_alpha, {CH_W{1'b0}}} - {{CH_W{1'b0}}, i_src_alpha};
        r1_wdst <= saob_pkg::t_wgt'(i_dst_alpha) *
                   saob_pkg::t_wgt'(saob_pkg::CH_MAX - i_src_alpha);
        r1_src  <= {i_src_blue, i_src_green, i_src_red};
        r1_dst  <= {i_dst_blue, i_dst_green, i_dst_red};
    end

    always_ff @(posedge i_clk) begin
        r2_cov <= r1_wsrc + r1_wdst;
        for (int c = 0; c < NCH; c++) begin
            r2_ps[c] <= saob_pkg::t_num'(r1_src[c]) * saob_pkg::t_num'(r1_wsrc);
            r2_pd[c] <= saob_pkg::t_num'(r1_dst[c]) * saob_pkg::t_num'(r1_wdst);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NCH; c++) begin
            r_rem[0][c] <= r2_ps[c] + r2_pd[c];
        end
        r_q[0]     <= '0;
        r_div[0]   <= r2_cov;
        r_alpha[0] <= saob_pkg::div255(r2_cov);
        r_nz[0]    <= (r2_cov != '0);
    end

    genvar gi;
    generate
        for (gi = 0; gi < CH_W; gi++) begin : g_div
            localparam int BIT = CH_W - 1 - gi;

            saob_pkg::t_num      dsh;
            saob_pkg::t_rgb_num  n_rem;
            saob_pkg::t_rgb      n_q;

            assign dsh = saob_pkg::t_num'(r_div[gi]) << BIT;

            always_comb begin
                for (int c = 0; c < NCH; c++) begin
                    if (r_nz[gi] && (r_rem[gi][c] >= dsh)) begin
                        n_rem[c] = r_rem[gi][c] - dsh;
                        n_q[c]   = {r_q[gi][c][CH_W-2:0], 1'b1};
                    end else begin
                        n_rem[c] = r_rem[gi][c];
                        n_q[c]   = {r_q[gi][c][CH_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[gi+1] <= 1'b0;
                end else begin
                    r_vld[gi+1] <= r_vld[gi];
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[gi+1]   <= n_rem;
                r_q[gi+1]     <= n_q;
                r_div[gi+1]   <= r_div[gi];
                r_alpha[gi+1] <= r_alpha[gi];
                r_nz[gi+1]    <= r_nz[gi];
            end
        end
    endgenerate

    assign o_valid     = r_vld[CH_W];
    assign o_out_alpha = r_alpha[CH_W];
    assign o_out_red   = r_q[CH_W][0];
    assign o_out_green = r_q[CH_W][1];
    assign o_out_blue  = r_q[CH_W][2];

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(saob_pkg::LATENCY) o_valid)
        else $error("accepted beat did not appear at the output");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, saob_pkg::LATENCY))
        else $error("output beat without an accepted input");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_nz[CH_W]) |->
            (r_rem[CH_W][0] < saob_pkg::t_num'(r_div[CH_W]) &&
             r_rem[CH_W][1] < saob_pkg::t_num'(r_div[CH_W]) &&
             r_rem[CH_W][2] < saob_pkg::t_num'(r_div[CH_W])))
        else $error("divide remainder not reduced below coverage");

    a_zero_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_nz[CH_W]) |->
            (o_out_red == '0 && o_out_green == '0 && o_out_blue == '0 && o_out_alpha == '0))
        else $error("zero coverage gave nonzero pixel");

    a_opaque_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_src_alpha == saob_pkg::CH_MAX) |-> ##(saob_pkg::LATENCY)
            (o_out_alpha == saob_pkg::CH_MAX &&
             o_out_red == $past(i_src_red, saob_pkg::LATENCY) &&
             o_out_blue == $past(i_src_blue, saob_pkg::LATENCY)))
        else $error("opaque source not passed through");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    typedef saob_pkg::t_chan t_chan;

    typedef struct packed {
        t_chan sa, sr, sg, sb;
        t_chan da, dr, dg, db;
    } t_pair;

    typedef struct packed {
        t_chan alpha, red, green, blue;
    } t_blend;

    typedef struct packed {
        t_pair  px;
        logic   typed;
        t_blend want;
    } t_row;

    localparam int DIR_N      = 20;
    localparam int RAND_N     = 1430;
    localparam int WDOG_LIMIT = 2000;

    // extremes first, zero coverage included, then odd alpha mixes left to the predictor
    t_row dir_tab [DIR_N] = '{
        '{'{  0,   0,   0,   0,   0,   0,   0,   0}, 1'b1, '{  0,   0,   0,   0}},
        '{'{  0, 255, 255, 255,   0, 255, 255, 255}, 1'b1, '{  0,   0,   0,   0}},
        '{'{255, 255,   0, 128,   0,   1,   2,   3}, 1'b1, '{255, 255,   0, 128}},
        '{'{255,  12,  34,  56, 255, 200, 100,  50}, 1'b1, '{255,  12,  34,  56}},
        '{'{  0,   9,   9,   9, 255, 255, 128,   1}, 1'b1, '{255, 255, 128,   1}},
        '{'{  0, 200, 201, 202,   1,  77,  88,  99}, 1'b1, '{  1,  77,  88,  99}},
        '{'{  1,  10,  20,  30,   0, 250, 251, 252}, 1'b1, '{  1,  10,  20,  30}},
        '{'{255, 255, 255, 255, 255, 255, 255, 255}, 1'b1, '{255, 255, 255, 255}},
        '{'{255,   0,   0,   0, 255, 255, 255, 255}, 1'b1, '{255,   0,   0,   0}},
        '{'{  0, 255, 255, 255, 255,   0,   0,   0}, 1'b1, '{255,   0,   0,   0}},
        '{'{  1, 255, 255, 255, 255,   0,   0,   0}, 1'b0, '{  0,   0,   0,   0}},
        '{'{254,   0,   0,   0, 255, 255, 255, 255}, 1'b0, '{  0,   0,   0,   0}},
        '{'{128, 255,   0, 170, 128,   0, 255,  85}, 1'b0, '{  0,   0,   0,   0}},
        '{'{127, 255, 255, 255,   0,   0,   0,   0}, 1'b0, '{  0,   0,   0,   0}},
        '{'{  1, 255,   0, 255,   1,   0, 255,   0}, 1'b0, '{  0,   0,   0,   0}},
        '{'{254, 255, 255,   0,   1,   0,   0, 255}, 1'b0, '{  0,   0,   0,   0}},
        '{'{  1,   0, 255, 255, 254, 255,   0,   0}, 1'b0, '{  0,   0,   0,   0}},
        '{'{ 85, 170, 170, 170, 170,  85,  85,  85}, 1'b0, '{  0,   0,   0,   0}},
        '{'{170,  85,  85,  85,  85, 170, 170, 170}, 1'b0, '{  0,   0,   0,   0}},
        '{'{ 64,  13, 140, 231, 192, 250,  77,   6}, 1'b0, '{  0,   0,   0,   0}}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [7:0] i_src_alpha, i_src_red, i_src_green, i_src_blue;
    logic [7:0] i_dst_alpha, i_dst_red, i_dst_green, i_dst_blue;
    logic       o_valid;
    logic [7:0] o_out_alpha, o_out_red, o_out_green, o_out_blue;

    t_blend expected_pixels[$];
    t_blend next_blend;
    int     mismatches     = 0;
    int     pixels_sent    = 0;
    int     pixels_blended = 0;
    int     clear_pairs    = 0;
    int     no_idle_left   = 0;
    int     idle_cycles;

    straight_alpha_over_blend uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_src_alpha (i_src_alpha),
        .i_src_red   (i_src_red),
        .i_src_green (i_src_green),
        .i_src_blue  (i_src_blue),
        .i_dst_alpha (i_dst_alpha),
        .i_dst_red   (i_dst_red),
        .i_dst_green (i_dst_green),
        .i_dst_blue  (i_dst_blue),
        .o_valid     (o_valid),
        .o_out_alpha (o_out_alpha),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_blend blend_over(input t_pair p);
        logic [31:0] w_src, w_dst, cov;
        t_blend r;
        w_src = p.sa * 32'd255;
        w_dst = p.da * (32'd255 - p.sa);
        cov   = w_src + w_dst;
        r.alpha = t_chan'(cov / 32'd255);
        if (cov == 0) begin
            r.red   = '0;
            r.green = '0;
            r.blue  = '0;
        end else begin
            r.red   = t_chan'((p.sr * w_src + p.dr * w_dst) / cov);
            r.green = t_chan'((p.sg * w_src + p.dg * w_dst) / cov);
            r.blue  = t_chan'((p.sb * w_src + p.db * w_dst) / cov);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 25) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic check_chan(input string name, input logic [7:0] got, input t_chan want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                      pixels_blended, name, got, want));
        end
    endtask

    function automatic t_chan pick_alpha();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            3: return 8'd254;
            default: return t_chan'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_chan pick_colour();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
        return t_chan'($urandom_range(0, 255));
    endfunction

    function automatic int pick_gap();
        int roll;
        if (no_idle_left > 0) begin
            no_idle_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            no_idle_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 11);
        return $urandom_range(20, 40);
    endfunction

    task automatic drive_pixel(input t_pair px, input logic typed, input t_blend want,
                               input bit drain);
        int gap;
        gap = pick_gap();
        if (drain) begin
            start <= 1'b0;
            do @(posedge i_clk); while (expected_pixels.size() != 0);
        end else if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_src_alpha <= px.sa;
        i_src_red   <= px.sr;
        i_src_green <= px.sg;
        i_src_blue  <= px.sb;
        i_dst_alpha <= px.da;
        i_dst_red   <= px.dr;
        i_dst_green <= px.dg;
        i_dst_blue  <= px.db;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_pixels.push_back(typed ? want : blend_over(px));
        pixels_sent++;
        if (px.sa == 0 && px.da == 0) clear_pairs++;
    endtask

    // result side: one beat per o_valid cycle, no back pressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("result beat with nothing pending");
            end else begin
                next_blend = expected_pixels.pop_front();
                check_chan("alpha", o_out_alpha, next_blend.alpha);
                check_chan("red",   o_out_red,   next_blend.red);
                check_chan("green", o_out_green, next_blend.green);
                check_chan("blue",  o_out_blue,  next_blend.blue);
                pixels_blended++;
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || o_valid || (start && !busy)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("timeout: no beat for %0d cycles", WDOG_LIMIT);
        $display("[straight_alpha_over_blend] ERROR");
        $finish;
    end

    initial begin
        t_pair px;
        bit    drain;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_src_alpha <= '0;
        i_src_red   <= '0;
        i_src_green <= '0;
        i_src_blue  <= '0;
        i_dst_alpha <= '0;
        i_dst_red   <= '0;
        i_dst_green <= '0;
        i_dst_blue  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            drive_pixel(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].want, 1'b0);
        end

        for (int i = 0; i < RAND_N; i++) begin
            px.sa = pick_alpha();
            px.da = pick_alpha();
            px.sr = pick_colour();
            px.sg = pick_colour();
            px.sb = pick_colour();
            px.dr = pick_colour();
            px.dg = pick_colour();
            px.db = pick_colour();
            drain = (i == RAND_N / 3) || (i == 2 * RAND_N / 3);
            drive_pixel(px, 1'b0, '0, drain);
        end
        start <= 1'b0;

        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (saob_pkg::LATENCY + 4) @(posedge i_clk);

        $display("sent %0d pixel pairs (%0d from the table, %0d with both alphas zero)",
                 pixels_sent, DIR_N, clear_pairs);
        $display("checked %0d blended pixels, %0d field mismatches",
                 pixels_blended, mismatches);
        if (mismatches == 0) begin
            $display("[straight_alpha_over_blend] OK");
        end else begin
            $display("[straight_alpha_over_blend] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/saob_pkg.sv
design/straight_alpha_over_blend.sv
test/tb_top.sv
